// ----- rtl/md5lh_pkg.sv -----
`timescale 1ns / 1ps
// md5lh_pkg: shared constants, round tables and helpers for the MD5 line hasher.
// No dependencies.
package md5lh_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  DELIM_RESET = 8'd10;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } chain_t;

  typedef struct packed {
    logic       start;
    logic [5:0] round;
  } rnd_ctl_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    begin
      case ({i[5:4], i[1:0]})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // message word index used by round i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    begin
      case (i[5:4])
        2'd0: g = i[3:0];
        2'd1: g = 4'(5 * i + 1);
        2'd2: g = 4'(3 * i + 5);
        default: g = 4'(7 * i);
      endcase
      return g;
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib > 4'd9) ? (8'(nib) + 8'h61 - 8'd10) : (8'(nib) + 8'h30);
  endfunction

endpackage

// ----- rtl/md5lh_if.sv -----
`timescale 1ns / 1ps
// md5lh_if: valid/ready channel interfaces for input, output and config words.
// No dependencies.
interface md5lh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       flush;
  modport source (output valid, data_byte, flush, input ready);
  modport sink (input valid, data_byte, flush, output ready);
endinterface

interface md5lh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  modport source (output valid, out_char, last, input ready);
  modport sink (input valid, out_char, last, output ready);
endinterface

interface md5lh_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/md5lh_ram.sv -----
`timescale 1ns / 1ps
// md5lh_ram: generic simple dual-port RAM (one write port, one read port), registered read.
// No dependencies.
module md5lh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/md5lh_round.sv -----
`timescale 1ns / 1ps
// md5lh_round: one MD5 round per cycle over a working register set.
// Depends on md5lh_pkg. Message word arrives registered from the block RAM.
module md5lh_round import md5lh_pkg::*; (
  input  logic        clk,
  input  rnd_ctl_t    ctl,
  input  chain_t      init,
  input  logic [31:0] w,
  output chain_t      work
);
  chain_t      work_r, work_nxt;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;
  chain_t      src;

  always_comb begin
    src = work_r;
    case (ctl.round[5:4])
      2'd0: f = (src.b & src.c) | (~src.b & src.d);
      2'd1: f = (src.d & src.b) | (~src.d & src.c);
      2'd2: f = src.b ^ src.c ^ src.d;
      default: f = src.c ^ (src.b | ~src.d);
    endcase
    s   = md5_s(ctl.round);
    sum = src.a + f + md5_k(ctl.round) + w;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    work_nxt.a = src.d;
    work_nxt.d = src.c;
    work_nxt.c = src.b;
    work_nxt.b = src.b + rot;
  end

  // start loads the chain value; rounds follow on the next cycles
  always_ff @(posedge clk) begin
    work_r <= ctl.start ? init : work_nxt;
  end

  assign work = work_r;
endmodule

// ----- rtl/md5_line_hasher_hex.sv -----
`timescale 1ns / 1ps
// md5_line_hasher_hex: MD5 of delimiter-separated records, emitted as hex text.
// Depends on md5lh_pkg, md5lh_if, md5lh_ram, md5lh_round.
//
// Usage:
//   in  : one word per stream byte (data_byte, flush). A byte equal to the
//         delimiter ends a record; flush ends a pending record at stream end.
//   out : per record 32 lowercase hex digits of the digest, then the
//         delimiter with last = 1.
//   cfg : writes the delimiter byte; write only while the block is idle.
// Sequence:
//   A plain byte is only accepted and written; a byte that fills a 64-byte
//   block also takes load, 64 rounds of the shared round unit and chain add.
//   A record end pads the buffer (one byte a cycle through the single buffer
//   write port), runs one or two compressions, then emits 33 words, one per
//   cycle while out_ready is high. Input is not accepted again until the
//   block is back in idle.
// Reset: synchronous active-low rst_n restores the MD5 IV, clears the bit
//   count and sets the delimiter to 10. in_ready is low while busy; a stalled
//   receiver holds the current output word and the block waits.
module md5_line_hasher_hex import md5lh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  md5lh_in_if.sink    in_ch,
  md5lh_out_if.source out_ch,
  md5lh_cfg_if.sink   cfg_ch
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [7:0]  delim_r;
  chain_t      chain_r;
  logic [63:0] bits_r;
  logic        pend_r;
  logic        fin_r;        // compressing as part of record end
  logic        last_blk_r;   // final (length) block
  logic        pad2_r;       // second block of a record end: zero padding and length, no 0x80 byte
  logic [5:0]  pos_r;        // pad write position
  logic [6:0]  cnt_r;        // round counter / emit counter
  logic        ld_r;

  logic        we;
  logic [5:0]  waddr;
  logic [7:0]  wdata;
  logic [3:0]  raddr;
  logic [31:0] rword;
  rnd_ctl_t    ctl;
  chain_t      work;

  logic        acc;
  logic [5:0]  bpos;
  logic [7:0]  emit_byte;
  logic [3:0]  nib;

  // four byte lanes so a 32-bit word is read per cycle
  genvar gi;
  generate
    for (gi = 0; gi < 4; gi++) begin : g_lane
      md5lh_ram #(.WIDTH(8), .DEPTH(16)) u_ram (
        .clk(clk),
        .we(we && (waddr[1:0] == 2'(gi))),
        .waddr(waddr[5:2]),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rword[8*gi +: 8])
      );
    end
  endgenerate

  md5lh_round u_round (
    .clk(clk), .ctl(ctl), .init(chain_r), .w(rword), .work(work)
  );

  assign bpos         = bits_r[8:3];
  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // RAM address leads the round: word g(round + 1) is read while round is computed
  assign raddr     = md5_g(ld_r ? 6'd0 : 6'(cnt_r + 7'd1));
  assign ctl.start = ld_r;
  assign ctl.round = cnt_r[5:0];

  always_comb begin
    we = 1'b0; waddr = bpos; wdata = in_ch.data_byte;
    if (state_r == ST_IDLE) begin
      we = acc && !in_ch.flush && (in_ch.data_byte != delim_r);
    end else if (state_r == ST_PAD) begin
      we = 1'b1; waddr = pos_r;
      wdata = (pos_r == bpos && !pad2_r) ? PAD_BYTE : 8'h00;
    end else if (state_r == ST_LEN) begin
      we = 1'b1; waddr = pos_r;
      wdata = bits_r[8*pos_r[2:0] +: 8];
    end
  end

  always_comb begin
    emit_byte = chain_r.a[7:0];
    case (cnt_r[4:3])
      2'd0: emit_byte = chain_r.a[8*cnt_r[2:1] +: 8];
      2'd1: emit_byte = chain_r.b[8*cnt_r[2:1] +: 8];
      2'd2: emit_byte = chain_r.c[8*cnt_r[2:1] +: 8];
      default: emit_byte = chain_r.d[8*cnt_r[2:1] +: 8];
    endcase
    nib = cnt_r[0] ? 4'(emit_byte & 8'h0f) : 4'((emit_byte & 8'hf0) >> 4);
  end

  assign out_ch.valid    = (state_r == ST_EMIT);
  assign out_ch.last     = cnt_r[5];
  assign out_ch.out_char = cnt_r[5] ? delim_r : hex_char(nib);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.flush ? pend_r : (in_ch.data_byte == delim_r)) begin
            state_nxt = ST_PAD;
          end else if (!in_ch.flush && (bpos == 6'd63)) begin
            state_nxt = ST_RND;
          end
        end
      end
      ST_PAD: begin
        if (pos_r == 6'd63) begin
          state_nxt = ST_RND;
        end else if (pos_r == 6'd55 && (bpos < 6'd56 || pad2_r)) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN:  if (pos_r == 6'd63) state_nxt = ST_RND;
      ST_RND:  if (!ld_r && cnt_r == 7'd63) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = !fin_r ? ST_IDLE : (last_blk_r ? ST_EMIT : ST_PAD);
      ST_EMIT: if (out_ch.ready && cnt_r == 7'd32) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      delim_r <= DELIM_RESET;
      chain_r <= '{IV_A, IV_B, IV_C, IV_D};
      bits_r  <= '0;
      pend_r  <= 1'b0;
      fin_r   <= 1'b0;
      last_blk_r <= 1'b0;
      pad2_r  <= 1'b0;
      pos_r   <= '0;
      cnt_r   <= '0;
      ld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) delim_r <= cfg_ch.data;
      case (state_r)
        ST_IDLE: begin
          ld_r <= 1'b1; cnt_r <= '0; pad2_r <= 1'b0;
          if (acc && !in_ch.flush && in_ch.data_byte != delim_r) begin
            bits_r <= bits_r + 64'd8;
            pend_r <= 1'b1;
            fin_r  <= 1'b0;
          end else begin
            fin_r <= 1'b1; last_blk_r <= 1'b0; pos_r <= bpos;
          end
        end
        ST_PAD: begin
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd55 && (bpos < 6'd56 || pad2_r)) last_blk_r <= 1'b1;
        end
        ST_LEN: pos_r <= pos_r + 6'd1;
        ST_RND: begin
          ld_r <= 1'b0;
          if (!ld_r) cnt_r <= cnt_r + 7'd1;
        end
        ST_ADD: begin
          chain_r.a <= chain_r.a + work.a;
          chain_r.b <= chain_r.b + work.b;
          chain_r.c <= chain_r.c + work.c;
          chain_r.d <= chain_r.d + work.d;
          ld_r <= 1'b1; cnt_r <= '0; pos_r <= '0;
          pad2_r <= fin_r && !last_blk_r;
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'd32) begin
              chain_r <= '{IV_A, IV_B, IV_C, IV_D};
              bits_r  <= '0;
              pend_r  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
